// ===== rtl/cnms_pkg.sv =====
// shared types and constants for the non-maximum suppression block
`default_nettype none
package cnms_pkg;
    localparam int MAX_WIDTH = 2048;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int GRAD_BITS = 16;
    localparam int MAG_BITS = GRAD_BITS + 1;
    localparam int SQ_BITS = 2 * GRAD_BITS + 2;
    localparam int SQRT_STEPS = SQ_BITS / 2;
    localparam int OUT_BITS = 20;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_BORDER = 3'd2,
        CFG_SCALE  = 3'd3,
        CFG_LIMIT  = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_READ,
        ST_TEST,
        ST_CMP,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [11:0] image_width;
        logic [15:0] image_height;
        logic [4:0]  border_width;
        logic [15:0] magnitude_scale;
        logic [15:0] magnitude_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] gx;
        logic signed [GRAD_BITS-1:0] gy;
    } gpair_t;
endpackage
`default_nettype wire

// ===== rtl/cnms_sqrt.sv =====
// iterative integer square root, one result bit per cycle
`default_nettype none
module cnms_sqrt (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [cnms_pkg::SQ_BITS-1:0] radicand,
    output logic done,
    output logic [cnms_pkg::MAG_BITS-1:0] root
);
    import cnms_pkg::*;

    logic [SQ_BITS-1:0] rem_reg, rem_next;
    logic [MAG_BITS-1:0] root_reg, root_next;
    logic [SQ_BITS-1:0] val_reg, val_next;
    logic [$clog2(SQRT_STEPS+1)-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [SQ_BITS-1:0] trial, rem_sh;

    always_comb
    begin
        rem_sh = {rem_reg[SQ_BITS-3:0], val_reg[SQ_BITS-1 -: 2]};
        trial = {{(SQ_BITS-MAG_BITS-2){1'b0}}, root_reg, 2'b01};
        rem_next = rem_reg;
        root_next = root_reg;
        val_next = val_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next = '0;
            root_next = '0;
            val_next = radicand;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[SQ_BITS-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = rem_sh - trial;
                root_next = {root_reg[MAG_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                root_next = {root_reg[MAG_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_STEPS[$bits(cnt_reg)-1:0] - 1'b1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        val_reg <= val_next;
    end

    assign done = busy_reg && !busy_next;
    assign root = root_next;
endmodule
`default_nettype wire

// ===== rtl/cnms_lines.sv =====
// line buffer memories for magnitudes and gradients, with registered reads
`default_nettype none
module cnms_lines (
    input  wire logic clk,
    input  wire logic rd_en,
    input  wire logic wr_en,
    input  wire logic [cnms_pkg::COL_BITS-1:0] addr,
    input  wire logic [cnms_pkg::MAG_BITS-1:0] wr_mag,
    input  wire cnms_pkg::gpair_t wr_grad,
    output logic [cnms_pkg::MAG_BITS-1:0] rd_upper,
    output logic [cnms_pkg::MAG_BITS-1:0] rd_middle,
    output cnms_pkg::gpair_t rd_grad
);
    import cnms_pkg::*;

    logic [MAG_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [MAG_BITS-1:0] middle_mem [MAX_WIDTH];
    gpair_t grad_mem [MAX_WIDTH];

    // write back reuses the middle value read in the earlier cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper <= upper_mem[addr];
            rd_middle <= middle_mem[addr];
            rd_grad <= grad_mem[addr];
        end
        if (wr_en)
        begin
            upper_mem[addr] <= rd_middle;
            middle_mem[addr] <= wr_mag;
            grad_mem[addr] <= wr_grad;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/canny_nonmax_suppression.sv =====
// top level: canny non-maximum suppression over a gradient raster stream
`default_nettype none
// Takes one gradient pair per request and returns one result per request, in
// order, with one request in flight at a time. A request is accepted in the idle
// state, and its result then passes through the states in order: ST_SQRT for the
// bit-serial square root, during which the line buffers are read at the current
// column; ST_READ to shift the window and write the line buffers back; ST_TEST
// for the test products; ST_CMP for the comparison and the scaled magnitude;
// ST_SCALE, which waits while an earlier result is still stalled; and ST_OUT to
// load the output register. The next request is accepted only after the block
// has returned to the idle state, so requests never overlap. Line buffers are
// single-port memories read and written back at the current column; unwritten
// entries reach only border centres, so no clearing pass is needed.
module canny_nonmax_suppression (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic signed [15:0] grad_x,
    input  wire logic signed [15:0] grad_y,
    input  wire logic frame_start,
    output logic res_valid,
    input  wire logic res_stall,
    output logic out_valid,
    output logic [19:0] edge_magnitude,
    output logic is_maximum,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [15:0] cfg_data
);
    import cnms_pkg::*;

    state_t state_reg, state_next;
    cfg_t cfg_reg;
    logic [COL_BITS:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [MAG_BITS-1:0] win_reg [9];
    gpair_t cg0_reg, cg1_reg, cur_reg;
    logic [COL_BITS:0] ccol_reg;
    logic [15:0] crow_reg;
    logic [MAG_BITS-1:0] mag_reg;

    logic [COL_BITS:0] w_eff;
    logic [15:0] h_eff;
    logic [4:0] b_eff;

    logic accept, sq_done;
    logic [SQ_BITS-1:0] sq_in;
    logic [MAG_BITS-1:0] sq_root;
    logic [MAG_BITS-1:0] rd_upper, rd_middle;
    gpair_t rd_grad;
    logic [COL_BITS-1:0] addr;

    logic signed [SQ_BITS+4:0] c_reg, a_reg, b_reg;
    logic valid_reg, ismax_reg, border_reg;
    logic [OUT_BITS-1:0] mag_out_reg;

    logic res_valid_reg;
    logic out_valid_reg, is_max_out_reg;
    logic [OUT_BITS-1:0] edge_out_reg;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        w_eff = (cfg_reg.image_width < 12'd3) ? (COL_BITS+1)'(3) :
                (cfg_reg.image_width > 12'(MAX_WIDTH)) ? (COL_BITS+1)'(MAX_WIDTH) :
                (COL_BITS+1)'(cfg_reg.image_width);
        h_eff = (cfg_reg.image_height < 16'd3) ? 16'd3 : cfg_reg.image_height;
        b_eff = (cfg_reg.border_width == 5'd0) ? 5'd1 : cfg_reg.border_width;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width <= 12'd640;
            cfg_reg.image_height <= 16'd480;
            cfg_reg.border_width <= 5'd2;
            cfg_reg.magnitude_scale <= 16'd25600;
            cfg_reg.magnitude_limit <= 16'd16000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WIDTH:  cfg_reg.image_width <= cfg_data[11:0];
                CFG_HEIGHT: cfg_reg.image_height <= cfg_data;
                CFG_BORDER: cfg_reg.border_width <= cfg_data[4:0];
                CFG_SCALE:  cfg_reg.magnitude_scale <= cfg_data;
                CFG_LIMIT:  cfg_reg.magnitude_limit <= cfg_data;
                default: ;
            endcase
        end
    end

    // position of the accepted pixel after frame start and wrap rules
    logic [COL_BITS:0] pc;
    logic [15:0] pr;
    always_comb
    begin
        pc = frame_start ? '0 : col_reg;
        pr = frame_start ? '0 : row_reg;
        if (pc >= w_eff)
        begin
            pc = '0;
            pr = pr + 16'd1;
        end
        if (pr >= h_eff)
            pr = '0;
        col_next = pc + 1'b1;
        row_next = pr;
        if (col_next >= w_eff)
        begin
            col_next = '0;
            row_next = pr + 16'd1;
            if (row_next >= h_eff)
                row_next = '0;
        end
    end

    assign sq_in = SQ_BITS'($signed(grad_x) * $signed(grad_x))
                 + SQ_BITS'($signed(grad_y) * $signed(grad_y));

    cnms_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(accept), .radicand(sq_in),
        .done(sq_done), .root(sq_root)
    );

    assign addr = ccol_reg[COL_BITS] ? COL_BITS'(MAX_WIDTH - 1) : ccol_reg[COL_BITS-1:0];

    cnms_lines u_lines (
        .clk(clk), .rd_en(state_reg == ST_SQRT), .wr_en(state_reg == ST_READ),
        .addr(addr), .wr_mag(mag_reg), .wr_grad(cur_reg),
        .rd_upper(rd_upper), .rd_middle(rd_middle), .rd_grad(rd_grad)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SQRT;
            ST_SQRT:  if (sq_done) state_next = ST_READ;
            ST_READ:  state_next = ST_TEST;
            ST_TEST:  state_next = ST_CMP;
            ST_CMP:   state_next = ST_SCALE;
            ST_SCALE: if (!res_valid_reg || !res_stall) state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            cg0_reg <= '0;
            cg1_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (state_reg == ST_READ)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3] <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= rd_upper;
                win_reg[5] <= rd_middle;
                win_reg[8] <= mag_reg;
                cg1_reg <= cg0_reg;
                cg0_reg <= rd_grad;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg.gx <= grad_x;
            cur_reg.gy <= grad_y;
            ccol_reg <= pc;
            crow_reg <= pr;
        end
        if (sq_done)
            mag_reg <= sq_root;
    end

    // interpolated local maximum test on the window centre
    logic signed [GRAD_BITS:0] gx, gy, agx, agy, sum_t;
    logic signed [MAG_BITS:0] wm, wa1, wb1, wa2, wb2;
    logic signed [SQ_BITS+4:0] c_n, a_n, b_n, pa1, pa2, pb1, pb2;
    logic same, xdom;
    logic [COL_BITS:0] cx;
    logic [15:0] cy;
    always_comb
    begin
        gx = (GRAD_BITS+1)'(cg1_reg.gx);
        gy = (GRAD_BITS+1)'(cg1_reg.gy);
        agx = gx[GRAD_BITS] ? -gx : gx;
        agy = gy[GRAD_BITS] ? -gy : gy;
        same = (gx > 0 && gy > 0) || (gx < 0 && gy < 0);
        xdom = agx >= agy;
        wm = (MAG_BITS+1)'(win_reg[4]);
        if (!same)
        begin
            sum_t = gx + gy;
            if (xdom)
            begin
                wa1 = (MAG_BITS+1)'(win_reg[2]); wa2 = (MAG_BITS+1)'(win_reg[5]);
                wb1 = (MAG_BITS+1)'(win_reg[6]); wb2 = (MAG_BITS+1)'(win_reg[3]);
                c_n = gx * wm;
                pa1 = gy * wa1; pa2 = sum_t * wa2;
                pb1 = gy * wb1; pb2 = sum_t * wb2;
            end
            else
            begin
                wa1 = (MAG_BITS+1)'(win_reg[2]); wa2 = (MAG_BITS+1)'(win_reg[1]);
                wb1 = (MAG_BITS+1)'(win_reg[6]); wb2 = (MAG_BITS+1)'(win_reg[7]);
                c_n = gy * wm;
                pa1 = gx * wa1; pa2 = sum_t * wa2;
                pb1 = gx * wb1; pb2 = sum_t * wb2;
            end
            a_n = pa1 - pa2;
            b_n = pb1 - pb2;
        end
        else
        begin
            if (xdom)
            begin
                sum_t = gx - gy;
                wa1 = (MAG_BITS+1)'(win_reg[8]); wa2 = (MAG_BITS+1)'(win_reg[5]);
                wb1 = (MAG_BITS+1)'(win_reg[0]); wb2 = (MAG_BITS+1)'(win_reg[3]);
                c_n = gx * wm;
                pa1 = gy * wa1; pa2 = sum_t * wa2;
                pb1 = gy * wb1; pb2 = sum_t * wb2;
            end
            else
            begin
                sum_t = gy - gx;
                wa1 = (MAG_BITS+1)'(win_reg[8]); wa2 = (MAG_BITS+1)'(win_reg[7]);
                wb1 = (MAG_BITS+1)'(win_reg[0]); wb2 = (MAG_BITS+1)'(win_reg[1]);
                c_n = gy * wm;
                pa1 = gx * wa1; pa2 = sum_t * wa2;
                pb1 = gx * wb1; pb2 = sum_t * wb2;
            end
            a_n = pa1 + pa2;
            b_n = pb1 + pb2;
        end
        cx = ccol_reg - 1'b1;
        cy = crow_reg - 16'd1;
    end

    logic signed [SQ_BITS+4:0] ac, aa, ab;
    logic [MAG_BITS-1:0] clamped;
    logic [MAG_BITS+15:0] prod;
    always_comb
    begin
        ac = c_reg[SQ_BITS+4] ? -c_reg : c_reg;
        aa = a_reg[SQ_BITS+4] ? -a_reg : a_reg;
        ab = b_reg[SQ_BITS+4] ? -b_reg : b_reg;
        clamped = (win_reg[4] >= MAG_BITS'(cfg_reg.magnitude_limit)) ?
                  MAG_BITS'(cfg_reg.magnitude_limit) : win_reg[4];
        prod = (MAG_BITS+16)'(clamped) * (MAG_BITS+16)'(cfg_reg.magnitude_scale);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TEST)
        begin
            c_reg <= c_n;
            a_reg <= a_n;
            b_reg <= b_n;
            valid_reg <= (crow_reg != 16'd0) && (ccol_reg != '0);
            border_reg <= (cx < (COL_BITS+1)'(b_eff))
                       || ((COL_BITS+2)'(cx) + (COL_BITS+2)'(b_eff) >= (COL_BITS+2)'(w_eff))
                       || (cy < 16'(b_eff))
                       || (17'(cy) + 17'(b_eff) >= 17'(h_eff));
        end
        if (state_reg == ST_CMP)
        begin
            ismax_reg <= valid_reg && !border_reg && (ac >= aa) && (ac > ab);
            mag_out_reg <= OUT_BITS'(prod >> 12);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            out_valid_reg <= valid_reg;
            is_max_out_reg <= ismax_reg;
            edge_out_reg <= ismax_reg ? mag_out_reg : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign out_valid = out_valid_reg;
    assign is_maximum = is_max_out_reg;
    assign edge_magnitude = edge_out_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (!res_valid_reg || !res_stall))
        else $error("result overwritten while stalled");
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SQRT))
        else $error("request not started");
    a_max_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && is_max_out_reg) |-> out_valid_reg)
        else $error("maximum on invalid centre");
endmodule
`default_nettype wire

// ===== tb/canny_nonmax_suppression_tb.sv =====
// self-checking testbench for the canny non-maximum suppression block
`timescale 1ns / 100ps
`default_nettype none
module canny_nonmax_suppression_tb;
    import cnms_pkg::*;

    typedef struct {
        bit        valid;
        bit [19:0] magnitude;
        bit        peak;
    } edge_result_t;

    class nms_scoreboard;
        int unsigned width_reg, height_reg, border_reg, scale_reg, limit_reg;
        bit [16:0] upper_mags [MAX_WIDTH];
        bit [16:0] middle_mags [MAX_WIDTH];
        gpair_t row_grads [MAX_WIDTH];
        bit [16:0] window [9];
        gpair_t centre [2];
        int unsigned column, row;
        edge_result_t expected_edges [$];
        int mismatches;

        function new();
            width_reg = 640;
            height_reg = 480;
            border_reg = 2;
            scale_reg = 25600;
            limit_reg = 16000;
            foreach (upper_mags[i])
            begin
                upper_mags[i] = 0;
                middle_mags[i] = 0;
                row_grads[i] = '0;
            end
            foreach (window[i])
                window[i] = 0;
            centre[0] = '0;
            centre[1] = '0;
            column = 0;
            row = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, bit [15:0] data);
            case (idx)
                CFG_WIDTH:  width_reg = data[11:0];
                CFG_HEIGHT: height_reg = data;
                CFG_BORDER: border_reg = data[4:0];
                CFG_SCALE:  scale_reg = data;
                CFG_LIMIT:  limit_reg = data;
                default: ;
            endcase
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function longint mag_abs(longint v);
            return v < 0 ? -v : v;
        endfunction

        function bit is_ridge(longint gx, longint gy);
            longint m, n, s, w, e, ne, nw, se, sw, c, a, b;
            bit agree, x_major;
            m = window[4]; n = window[1]; s = window[7]; w = window[3]; e = window[5];
            nw = window[0]; ne = window[2]; sw = window[6]; se = window[8];
            agree = (gx > 0 && gy > 0) || (gx < 0 && gy < 0);
            x_major = mag_abs(gx) >= mag_abs(gy);
            if (!agree)
            begin
                if (x_major)
                begin
                    c = mag_abs(gx * m);
                    a = mag_abs(gy * ne - (gx + gy) * e);
                    b = mag_abs(gy * sw - (gx + gy) * w);
                end
                else
                begin
                    c = mag_abs(gy * m);
                    a = mag_abs(gx * ne - (gy + gx) * n);
                    b = mag_abs(gx * sw - (gy + gx) * s);
                end
            end
            else
            begin
                if (x_major)
                begin
                    c = mag_abs(gx * m);
                    a = mag_abs(gy * se + (gx - gy) * e);
                    b = mag_abs(gy * nw + (gx - gy) * w);
                end
                else
                begin
                    c = mag_abs(gy * m);
                    a = mag_abs(gx * se + (gy - gx) * s);
                    b = mag_abs(gx * nw + (gy - gx) * n);
                end
            end
            return c >= a && c > b;
        endfunction

        function void note_request(bit signed [15:0] gx, bit signed [15:0] gy, bit fs);
            int unsigned w, h, bw, cx, cy;
            longint sx, sy;
            bit [16:0] m;
            edge_result_t r;
            w = width_reg;
            h = height_reg;
            bw = border_reg;
            if (w < 3) w = 3;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            if (h < 3) h = 3;
            if (bw < 1) bw = 1;
            if (fs)
            begin
                column = 0;
                row = 0;
            end
            if (column >= w)
            begin
                column = 0;
                row++;
            end
            if (row >= h) row = 0;
            sx = gx;
            sy = gy;
            m = 17'(root_floor(sx * sx + sy * sy));
            for (int k = 0; k < 3; k++)
            begin
                window[k * 3] = window[k * 3 + 1];
                window[k * 3 + 1] = window[k * 3 + 2];
            end
            window[2] = upper_mags[column];
            window[5] = middle_mags[column];
            window[8] = m;
            centre[1] = centre[0];
            centre[0] = row_grads[column];
            upper_mags[column] = middle_mags[column];
            middle_mags[column] = m;
            row_grads[column].gx = gx;
            row_grads[column].gy = gy;
            r.valid = 0;
            r.magnitude = 0;
            r.peak = 0;
            if (row >= 1 && column >= 1)
            begin
                cx = column - 1;
                cy = row - 1;
                r.valid = 1;
                if (!(cx < bw || cx + bw >= w || cy < bw || cy + bw >= h))
                begin
                    if (is_ridge(centre[1].gx, centre[1].gy))
                    begin
                        r.peak = 1;
                        if (window[4] >= limit_reg)
                            r.magnitude = 20'((longint'(scale_reg) * limit_reg) >> 12);
                        else
                            r.magnitude = 20'((longint'(scale_reg) * window[4]) >> 12);
                    end
                end
            end
            expected_edges.push_back(r);
            column++;
            if (column >= w)
            begin
                column = 0;
                row++;
                if (row >= h) row = 0;
            end
        endfunction

        function void check_result(bit ov, bit [19:0] em, bit im);
            edge_result_t r;
            if (expected_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid %0d magnitude %0d maximum %0d",
                             ov, em, im);
                return;
            end
            r = expected_edges.pop_front();
            if (r.valid !== ov || r.magnitude !== em || r.peak !== im)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected valid %0d magnitude %0d maximum %0d, got %0d %0d %0d",
                             r.valid, r.magnitude, r.peak, ov, em, im);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic frame_start;
    logic res_valid;
    logic res_stall;
    logic out_valid;
    logic [19:0] edge_magnitude;
    logic is_maximum;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;

    nms_scoreboard board;
    bit result_taken;
    bit hold_off_req;
    bit sender_rush;
    int idle_cycles;
    bit timed_out;

    canny_nonmax_suppression dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .grad_x(grad_x),
        .grad_y(grad_y),
        .frame_start(frame_start),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .out_valid(out_valid),
        .edge_magnitude(edge_magnitude),
        .is_maximum(is_maximum),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                board.check_result(out_valid, edge_magnitude, is_maximum);
                result_taken = 1;
            end
            if ((res_valid && !res_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 20000 && !timed_out)
            begin
                timed_out = 1;
                $display("canny_nonmax_suppression regression: fail");
                $finish;
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int gap;
        bit calm;
        calm = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                res_stall <= 1'b1;
                repeat (400) @(negedge clk);
                res_stall <= 1'b0;
                hold_off_req = 0;
            end
            else if (result_taken)
            begin
                result_taken = 0;
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                gap = calm ? 0 : $urandom_range(0, 18);
                if (gap > 0)
                begin
                    res_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                    res_stall <= 1'b0;
                end
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, bit [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(bit [15:0] w, bit [15:0] h, bit [15:0] bw,
                                bit [15:0] sc, bit [15:0] lim);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_BORDER, bw);
        write_reg(CFG_SCALE, sc);
        write_reg(CFG_LIMIT, lim);
    endtask

    // one request; leaves in_valid high for a back-to-back follow-up
    task automatic send_request(bit signed [15:0] gx, bit signed [15:0] gy, bit fs);
        int gap;
        @(negedge clk);
        gap = sender_rush ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        grad_x <= gx;
        grad_y <= gy;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(gx, gy, fs);
    endtask

    function automatic bit [15:0] pick_grad();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            2, 3: return 16'($signed($urandom_range(0, 128)) - 64);
            4, 5: return 16'($signed($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_request(pick_grad(), pick_grad(), i == 0 || $urandom_range(0, 149) == 0);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.expected_edges.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    bit [15:0] directed_x [25] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff,
                                   16'h0100, 16'h0100, 16'h7fff, 16'h0000, 16'h8000,
                                   16'h0040, 16'hffc0, 16'h0200, 16'h0400, 16'h0200,
                                   16'h0010, 16'h0800, 16'hf800, 16'h0000, 16'h0300,
                                   16'h8001, 16'h0555, 16'haaaa, 16'h0020, 16'h0001};
    bit [15:0] directed_y [25] = '{16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'hffff,
                                   16'hff00, 16'h0100, 16'h8000, 16'h7fff, 16'h7fff,
                                   16'hffc0, 16'h0040, 16'h0100, 16'h0020, 16'hfe00,
                                   16'h0800, 16'h0010, 16'h0800, 16'h0000, 16'hfd00,
                                   16'h8001, 16'haaaa, 16'h5555, 16'hffe0, 16'h0000};

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        grad_x = '0;
        grad_y = '0;
        frame_start = 1'b0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        result_taken = 0;
        hold_off_req = 0;
        sender_rush = 0;
        idle_cycles = 0;
        timed_out = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short rows so that the directed pattern reaches interior centres
        set_geometry(6, 5, 1, 65535, 1000);
        for (int i = 0; i < 25; i++)
            send_request(directed_x[i], directed_y[i], i == 0);
        @(negedge clk);
        in_valid <= 1'b0;
        drain();

        set_geometry(5, 4, 1, 65535, 65535);
        run_random(150);
        drain();

        // long receiver hold-off while the sender keeps pushing
        set_geometry(16, 8, 1, 256, 16000);
        sender_rush = 1;
        hold_off_req = 1;
        run_random(300);
        sender_rush = 0;
        drain();

        set_geometry(12, 10, 2, 25600, 200);
        run_random(300);
        drain();

        // out-of-range sizes fall back to their limits
        set_geometry(0, 0, 0, 65535, 0);
        run_random(60);
        drain();

        set_geometry(4095, 65535, 31, 100, 50);
        run_random(40);
        drain();

        set_geometry(9, 7, 2, 4096, 65535);
        run_random(375);
        drain();

        if (board.mismatches == 0 && board.expected_edges.size() == 0)
            $display("canny_nonmax_suppression regression: pass");
        else
            $display("canny_nonmax_suppression regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/cnms_pkg.sv
rtl/cnms_sqrt.sv
rtl/cnms_lines.sv
rtl/canny_nonmax_suppression.sv
tb/canny_nonmax_suppression_tb.sv
